/* hw/rtl/mer_pkg.sv */
// shared constants and types for the midpoint ellipse rasterizer
// no dependencies; imported by mer_front and mer_back
package mer_pkg;

   localparam int DEC_BITS = 48;

   typedef logic [1:0] phase_type;

   localparam phase_type PH_IDLE = 2'd0;
   localparam phase_type PH_R1   = 2'd1;
   localparam phase_type PH_R2   = 2'd2;

   typedef logic kind_type;

   localparam kind_type KIND_START = 1'b0;

endpackage

/* hw/rtl/mer_fifo.sv */
// small register queue used for the command queue and the response queue
// standalone, no package dependency
module mer_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hw/rtl/mer_front.sv */
// request front end: classifies requests and derives centre and semi-axes
// depends on mer_pkg; feeds the command queue read by mer_back
module mer_front import mer_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_kind,
   input  logic [COORD_BITS-1:0] req_corner_ax,
   input  logic [COORD_BITS-1:0] req_corner_ay,
   input  logic [COORD_BITS-1:0] req_corner_bx,
   input  logic [COORD_BITS-1:0] req_corner_by,
   output logic                  cmd_push,
   output logic [4*COORD_BITS:0] cmd_data,
   input  logic                  cmd_full
);

   localparam int C = COORD_BITS;

   logic [C:0]   sum_x;
   logic [C:0]   sum_y;
   logic [C-1:0] cen_x;
   logic [C-1:0] cen_y;
   logic [C:0]   semi_a;
   logic [C:0]   semi_a_neg;
   logic [C-1:0] semi_a_mag;
   logic [C-1:0] y_min;
   logic [C-1:0] semi_b;
   logic         is_start;

   always_comb begin
      sum_x      = {1'b0, req_corner_ax} + {1'b0, req_corner_bx};
      sum_y      = {1'b0, req_corner_ay} + {1'b0, req_corner_by};
      cen_x      = sum_x[C:1];
      cen_y      = sum_y[C:1];
      semi_a     = {1'b0, cen_x} - {1'b0, req_corner_ax};
      semi_a_neg = (C+1)'(0) - semi_a;
      semi_a_mag = semi_a[C] ? semi_a_neg[C-1:0] : semi_a[C-1:0];
      y_min      = (req_corner_ay < req_corner_by) ? req_corner_ay : req_corner_by;
      semi_b     = cen_y - y_min;
      is_start   = (req_kind == KIND_START);
   end

   assign cmd_data = {is_start, cen_x, cen_y, semi_a_mag, semi_b};
   assign cmd_push = req_push;
   assign req_full = cmd_full;

endmodule

/* hw/rtl/mer_back.sv */
// back end: sequencer around one shared multiplier that runs the midpoint steps
// depends on mer_pkg; reads the command queue, writes the response queue
module mer_back import mer_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [4*COORD_BITS:0]         cmd_data,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   output logic                          rsp_push,
   output logic [8*(COORD_BITS+2)+1:0]   rsp_data,
   input  logic                          rsp_full
);

   localparam int C      = COORD_BITS;
   localparam int OUT_W  = C + 2;
   localparam int SQ_W   = 2 * C - 1;
   localparam int MB_W   = 2 * C + 2;
   localparam int PROD_W = SQ_W + MB_W;

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_S1   = 5'd1;
   localparam logic [4:0] ST_S2   = 5'd2;
   localparam logic [4:0] ST_S3   = 5'd3;
   localparam logic [4:0] ST_R1A  = 5'd4;
   localparam logic [4:0] ST_R1B  = 5'd5;
   localparam logic [4:0] ST_R1C  = 5'd6;
   localparam logic [4:0] ST_R1D  = 5'd7;
   localparam logic [4:0] ST_R1E  = 5'd8;
   localparam logic [4:0] ST_I2   = 5'd9;
   localparam logic [4:0] ST_I3   = 5'd10;
   localparam logic [4:0] ST_I4   = 5'd11;
   localparam logic [4:0] ST_I5   = 5'd12;
   localparam logic [4:0] ST_I6   = 5'd13;
   localparam logic [4:0] ST_R2A  = 5'd14;
   localparam logic [4:0] ST_R2B  = 5'd15;
   localparam logic [4:0] ST_R2C  = 5'd16;
   localparam logic [4:0] ST_OUT  = 5'd17;

   logic [4:0]          state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic                active_ff, active_in;
   logic                neg_ff, neg_in;
   logic [C-1:0]        ox_ff, ox_in;
   logic [C-1:0]        oy_ff, oy_in;
   logic [C-1:0]        cx_ff, cx_in;
   logic [C-1:0]        cy_ff, cy_in;
   logic [SQ_W-1:0]     as_ff, as_in;
   logic [SQ_W-1:0]     bs_ff, bs_in;
   logic [DEC_BITS-1:0] dec_ff, dec_in;
   logic [DEC_BITS-1:0] lhs_ff, lhs_in;
   logic [DEC_BITS-1:0] prod_ff;

   logic                cmd_start;
   logic [C-1:0]        cmd_cx;
   logic [C-1:0]        cmd_cy;
   logic [C-1:0]        cmd_amag;
   logic [C-1:0]        cmd_b;

   logic [C+1:0]        x2p1;
   logic [C+1:0]        x2p2;
   logic [C+1:0]        x2p3;
   logic [C:0]          y2m1;
   logic [C:0]          y2m2;
   logic [C:0]          y2m3;
   logic                y_is_one;
   logic [C:0]          y_r2;
   logic                r1_go;
   logic [DEC_BITS-1:0] prod4;

   logic [SQ_W-1:0]     mul_a;
   logic [MB_W-1:0]     mul_b;
   logic [PROD_W-1:0]   mul_p;

   logic [OUT_W-1:0]    xp;
   logic [OUT_W-1:0]    xm;
   logic [OUT_W-1:0]    yp;
   logic [OUT_W-1:0]    ym;

   assign cmd_start = cmd_data[4*C];
   assign cmd_cx    = cmd_data[4*C-1 -: C];
   assign cmd_cy    = cmd_data[3*C-1 -: C];
   assign cmd_amag  = cmd_data[2*C-1 -: C];
   assign cmd_b     = cmd_data[C-1:0];

   always_comb begin
      x2p1     = {1'b0, ox_ff, 1'b1};
      x2p2     = {1'b0, ox_ff, 1'b0} + (C+2)'(2);
      x2p3     = {1'b0, ox_ff, 1'b0} + (C+2)'(3);
      y2m1     = {oy_ff, 1'b0} - (C+1)'(1);
      y2m2     = {oy_ff, 1'b0} - (C+1)'(2);
      y2m3     = {oy_ff, 1'b0} - (C+1)'(3);
      y_is_one = (oy_ff == C'(1));
      y_r2     = y_is_one ? (C+1)'(1) : y2m3;
      r1_go    = (lhs_ff < prod_ff);
      prod4    = {prod_ff[DEC_BITS-3:0], 2'b00};
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_IDLE: begin
            mul_a = SQ_W'(cmd_amag);
            mul_b = MB_W'(cmd_amag);
         end
         ST_S1: begin
            mul_a = SQ_W'(oy_ff);
            mul_b = MB_W'(oy_ff);
         end
         ST_S2: begin
            mul_a = as_ff;
            mul_b = MB_W'(oy_ff);
         end
         ST_R1A: begin
            mul_a = bs_ff;
            mul_b = MB_W'(x2p2);
         end
         ST_R1B: begin
            mul_a = as_ff;
            mul_b = MB_W'(y2m1);
         end
         ST_R1C: begin
            if (r1_go) begin
               mul_a = bs_ff;
               mul_b = MB_W'(x2p3);
            end else begin
               mul_a = SQ_W'(x2p1);
               mul_b = MB_W'(x2p1);
            end
         end
         ST_R1D: begin
            mul_a = as_ff;
            mul_b = MB_W'(y2m2);
         end
         ST_I2: begin
            mul_a = bs_ff;
            mul_b = prod_ff[MB_W-1:0];
         end
         ST_I3: begin
            mul_a = SQ_W'(y2m2);
            mul_b = MB_W'(y2m2);
         end
         ST_I4: begin
            mul_a = as_ff;
            mul_b = prod_ff[MB_W-1:0];
         end
         ST_I5: begin
            mul_a = as_ff;
            mul_b = MB_W'(bs_ff);
         end
         ST_R2A: begin
            mul_a = as_ff;
            mul_b = MB_W'(y_r2);
         end
         ST_R2B: begin
            mul_a = bs_ff;
            mul_b = MB_W'(x2p2);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      active_in = active_ff;
      neg_in    = neg_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      as_in     = as_ff;
      bs_in     = bs_ff;
      dec_in    = dec_ff;
      lhs_in    = lhs_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_start) begin
                  cx_in     = cmd_cx;
                  cy_in     = cmd_cy;
                  ox_in     = '0;
                  oy_in     = cmd_b;
                  phase_in  = PH_R1;
                  active_in = 1'b1;
                  state_in  = ST_S1;
               end else if (phase_ff == PH_IDLE) begin
                  active_in = 1'b0;
                  state_in  = ST_OUT;
               end else begin
                  active_in = 1'b1;
                  state_in  = (phase_ff == PH_R1) ? ST_R1A : ST_R2A;
               end
            end
         end
         ST_S1: begin
            as_in    = prod_ff[SQ_W-1:0];
            state_in = ST_S2;
         end
         ST_S2: begin
            bs_in    = prod_ff[SQ_W-1:0];
            dec_in   = prod4 + DEC_BITS'(as_ff);
            state_in = ST_S3;
         end
         ST_S3: begin
            dec_in   = dec_ff - prod4;
            state_in = ST_OUT;
         end
         ST_R1A: begin
            state_in = ST_R1B;
         end
         ST_R1B: begin
            lhs_in   = prod_ff;
            state_in = ST_R1C;
         end
         ST_R1C: begin
            neg_in   = dec_ff[DEC_BITS-1];
            state_in = r1_go ? ST_R1D : ST_I2;
         end
         ST_R1D: begin
            dec_in = dec_ff + prod4;
            if (neg_ff) begin
               ox_in    = ox_ff + C'(1);
               state_in = ST_OUT;
            end else begin
               state_in = ST_R1E;
            end
         end
         ST_R1E: begin
            dec_in   = dec_ff - prod4;
            ox_in    = ox_ff + C'(1);
            oy_in    = oy_ff - C'(1);
            state_in = ST_OUT;
         end
         ST_I2: begin
            state_in = ST_I3;
         end
         ST_I3: begin
            dec_in   = prod_ff;
            state_in = ST_I4;
         end
         ST_I4: begin
            state_in = ST_I5;
         end
         ST_I5: begin
            dec_in   = dec_ff + prod_ff;
            state_in = ST_I6;
         end
         ST_I6: begin
            dec_in   = dec_ff - prod4;
            phase_in = PH_R2;
            state_in = ST_R2A;
         end
         ST_R2A: begin
            neg_in   = dec_ff[DEC_BITS-1];
            state_in = ST_R2B;
         end
         ST_R2B: begin
            dec_in = y_is_one ? (dec_ff + prod4) : (dec_ff - prod4);
            if (neg_ff) begin
               state_in = ST_R2C;
            end else begin
               oy_in    = oy_ff - C'(1);
               state_in = ST_OUT;
            end
         end
         ST_R2C: begin
            dec_in   = dec_ff + prod4;
            ox_in    = ox_ff + C'(1);
            oy_in    = oy_ff - C'(1);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (oy_ff == '0) begin
                  phase_in = PH_IDLE;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_IDLE;
         active_ff <= 1'b0;
         neg_ff    <= 1'b0;
         ox_ff     <= '0;
         oy_ff     <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
         as_ff     <= '0;
         bs_ff     <= '0;
         dec_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         active_ff <= active_in;
         neg_ff    <= neg_in;
         ox_ff     <= ox_in;
         oy_ff     <= oy_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         as_ff     <= as_in;
         bs_ff     <= bs_in;
         dec_ff    <= dec_in;
      end
   end

   always_ff @(posedge clock) begin
      lhs_ff  <= lhs_in;
      prod_ff <= DEC_BITS'(mul_p);
   end

   // four mirrored points around the centre
   always_comb begin
      xp = OUT_W'(cx_ff) + OUT_W'(ox_ff);
      xm = OUT_W'(cx_ff) - OUT_W'(ox_ff);
      yp = OUT_W'(cy_ff) + OUT_W'(oy_ff);
      ym = OUT_W'(cy_ff) - OUT_W'(oy_ff);
      if (active_ff) begin
         rsp_data = {1'b1, (oy_ff == '0), xp, yp, xm, yp, xm, ym, xp, ym};
      end else begin
         rsp_data = '0;
      end
   end

`ifndef ASSERT_OFF
   a_walk_has_height: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && phase_ff != PH_IDLE) |-> (oy_ff != '0))
      else $error("ellipse walk active with zero offset y");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after taking a command");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && oy_ff == '0) |=> (phase_ff == PH_IDLE))
      else $error("walk not closed after final group");

   a_r2_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R2A) |-> (phase_ff == PH_R2))
      else $error("region two step outside region two");
`endif

endmodule

/* hw/rtl/midpoint_ellipse_rasterizer.sv */
// midpoint ellipse rasterizer: accepts start and step requests, returns point groups
// depends on mer_pkg, mer_fifo, mer_front and mer_back
//
// request channel: req_push / req_full, a request is taken when req_push is high
// and req_full low. kind 0 starts a new ellipse from two box corners, kind 1
// advances the running ellipse by one point group.
// response channel: rsp_empty / rsp_pop, one response per request in order; the
// oldest response sits on the rsp_ ports while rsp_empty is low.
// requests pass through a command queue into a sequencer built around one
// shared multiplier; each request occupies that sequencer for its states:
//   start S1 to S3, region one step R1A to R1D and R1E if y moves, region two
//   step R2A, R2B and R2C if x moves, the switching step R1A to R1C, I2 to I6
//   and the region two states, a step with no ellipse none; OUT then responds.
// reset clears both queues and leaves no ellipse in progress.
// when the receiver stalls, the response queue fills, the sequencer waits with
// its finished response, then the command queue fills and req_full rises.
module midpoint_ellipse_rasterizer #(
   parameter int COORD_BITS = 12,
   parameter int CMD_DEPTH  = 2,
   parameter int RSP_DEPTH  = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_kind,
   input  logic [COORD_BITS-1:0]        req_corner_ax,
   input  logic [COORD_BITS-1:0]        req_corner_ay,
   input  logic [COORD_BITS-1:0]        req_corner_bx,
   input  logic [COORD_BITS-1:0]        req_corner_by,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic                         rsp_active,
   output logic                         rsp_last_group,
   output logic signed [COORD_BITS+1:0] rsp_pt0_x,
   output logic signed [COORD_BITS+1:0] rsp_pt0_y,
   output logic signed [COORD_BITS+1:0] rsp_pt1_x,
   output logic signed [COORD_BITS+1:0] rsp_pt1_y,
   output logic signed [COORD_BITS+1:0] rsp_pt2_x,
   output logic signed [COORD_BITS+1:0] rsp_pt2_y,
   output logic signed [COORD_BITS+1:0] rsp_pt3_x,
   output logic signed [COORD_BITS+1:0] rsp_pt3_y
);

   localparam int CMD_W = 4 * COORD_BITS + 1;
   localparam int OUT_W = COORD_BITS + 2;
   localparam int RSP_W = 8 * OUT_W + 2;

   logic             cmd_push;
   logic [CMD_W-1:0] cmd_wr_data;
   logic             cmd_full;
   logic             cmd_pop;
   logic [CMD_W-1:0] cmd_rd_data;
   logic             cmd_empty;
   logic             rsp_push;
   logic [RSP_W-1:0] rsp_wr_data;
   logic             rsp_full;
   logic [RSP_W-1:0] rsp_rd_data;

   mer_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_corner_ax (req_corner_ax),
      .req_corner_ay (req_corner_ay),
      .req_corner_bx (req_corner_bx),
      .req_corner_by (req_corner_by),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_wr_data),
      .cmd_full      (cmd_full)
   );

   mer_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr_data),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd_data),
      .empty   (cmd_empty)
   );

   mer_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_rd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr_data),
      .rsp_full  (rsp_full)
   );

   mer_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr_data),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd_data),
      .empty   (rsp_empty)
   );

   assign rsp_active     = rsp_rd_data[RSP_W-1];
   assign rsp_last_group = rsp_rd_data[RSP_W-2];
   assign rsp_pt0_x      = $signed(rsp_rd_data[8*OUT_W-1 -: OUT_W]);
   assign rsp_pt0_y      = $signed(rsp_rd_data[7*OUT_W-1 -: OUT_W]);
   assign rsp_pt1_x      = $signed(rsp_rd_data[6*OUT_W-1 -: OUT_W]);
   assign rsp_pt1_y      = $signed(rsp_rd_data[5*OUT_W-1 -: OUT_W]);
   assign rsp_pt2_x      = $signed(rsp_rd_data[4*OUT_W-1 -: OUT_W]);
   assign rsp_pt2_y      = $signed(rsp_rd_data[3*OUT_W-1 -: OUT_W]);
   assign rsp_pt3_x      = $signed(rsp_rd_data[2*OUT_W-1 -: OUT_W]);
   assign rsp_pt3_y      = $signed(rsp_rd_data[OUT_W-1 -: OUT_W]);

endmodule

/* verif/tb_midpoint_ellipse_rasterizer.sv */
// self-checking testbench for midpoint_ellipse_rasterizer: directed table, then random
// ellipses with random gaps on both channels, checked in order against an inline predictor
// depends on mer_pkg and the midpoint_ellipse_rasterizer rtl
`timescale 1ns / 1ps

module tb_midpoint_ellipse_rasterizer import mer_pkg::*; ();

   localparam int CB = 12;
   localparam int OB = CB + 2;
   localparam kind_type KIND_STEP = 1'b1;

   typedef struct packed {
      logic          active;
      logic          last_group;
      logic [OB-1:0] p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
   } point_group_type;

   typedef struct packed {
      kind_type        kind;
      logic [CB-1:0]   ax, ay, bx, by;
      logic            has_known;
      point_group_type known;
   } request_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_push = 1'b0;
   logic          req_full;
   kind_type      req_kind = KIND_START;
   logic [CB-1:0] req_corner_ax = '0;
   logic [CB-1:0] req_corner_ay = '0;
   logic [CB-1:0] req_corner_bx = '0;
   logic [CB-1:0] req_corner_by = '0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   logic          rsp_active, rsp_last_group;
   logic signed [OB-1:0] rsp_pt0_x, rsp_pt0_y, rsp_pt1_x, rsp_pt1_y;
   logic signed [OB-1:0] rsp_pt2_x, rsp_pt2_y, rsp_pt3_x, rsp_pt3_y;

   logic            cur_has_known = 1'b0;
   point_group_type cur_known = '0;
   logic            quiet = 1'b0;
   int              pop_hold = 0;
   int              faults = 0;
   point_group_type expected_groups[$];
   point_group_type want, got, predicted;
   request_type     directed_rows [25];

   // predictor state
   phase_type     ph = PH_IDLE;
   logic [CB-1:0] off_x = '0, off_y = '0, ctr_x = '0, ctr_y = '0;
   logic [47:0]   dec = '0;
   longint        a_sq = 0, b_sq = 0;

   midpoint_ellipse_rasterizer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_corner_ax  (req_corner_ax),
      .req_corner_ay  (req_corner_ay),
      .req_corner_bx  (req_corner_bx),
      .req_corner_by  (req_corner_by),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_active     (rsp_active),
      .rsp_last_group (rsp_last_group),
      .rsp_pt0_x      (rsp_pt0_x),
      .rsp_pt0_y      (rsp_pt0_y),
      .rsp_pt1_x      (rsp_pt1_x),
      .rsp_pt1_y      (rsp_pt1_y),
      .rsp_pt2_x      (rsp_pt2_x),
      .rsp_pt2_y      (rsp_pt2_y),
      .rsp_pt3_x      (rsp_pt3_x),
      .rsp_pt3_y      (rsp_pt3_y)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic point_group_type mirror_points();
      point_group_type g;
      logic [OB-1:0]   xp, xm, yp, ym;
      xp = OB'(ctr_x) + OB'(off_x);
      xm = OB'(ctr_x) - OB'(off_x);
      yp = OB'(ctr_y) + OB'(off_y);
      ym = OB'(ctr_y) - OB'(off_y);
      g.active = 1'b1;
      g.last_group = (off_y == '0);
      g.p0x = xp; g.p0y = yp;
      g.p1x = xm; g.p1y = yp;
      g.p2x = xm; g.p2y = ym;
      g.p3x = xp; g.p3y = ym;
      return g;
   endfunction

   function automatic point_group_type start_ellipse(input int ax, input int ay,
                                                     input int bx, input int by);
      int     cxi, cyi, ymin;
      longint a, b;
      cxi = (ax + bx) >> 1;
      cyi = (ay + by) >> 1;
      ymin = (ay < by) ? ay : by;
      a = cxi - ax;
      b = cyi - ymin;
      ctr_x = CB'(cxi);
      ctr_y = CB'(cyi);
      a_sq = a * a;
      b_sq = b * b;
      off_x = '0;
      off_y = CB'(b);
      dec = 48'(b * (4 * b - 4 * a_sq) + a_sq);
      ph = (b == 0) ? PH_IDLE : PH_R1;
      return mirror_points();
   endfunction

   function automatic void walk_region_two();
      longint x, y;
      x = off_x;
      y = off_y;
      if (dec[47]) begin
         dec = dec + 48'(4 * (b_sq * (2 * x + 2) + a_sq * (-2 * y + 3)));
         off_x = off_x + 1'b1;
      end else begin
         dec = dec + 48'(4 * a_sq * (-2 * y + 3));
      end
      off_y = off_y - 1'b1;
   endfunction

   function automatic point_group_type advance_ellipse();
      longint     x, y;
      bit [63:0]  xu, ym1, au, bu, t;
      if (ph == PH_IDLE)
         return '0;
      if (ph == PH_R1) begin
         x = off_x;
         y = off_y;
         if (b_sq * 2 * (x + 1) < a_sq * (2 * y - 1)) begin
            if (dec[47]) begin
               dec = dec + 48'(4 * (b_sq * (2 * x + 3)));
            end else begin
               dec = dec + 48'(4 * (b_sq * (2 * x + 3) + a_sq * (-2 * y + 2)));
               off_y = off_y - 1'b1;
            end
            off_x = off_x + 1'b1;
         end else begin
            // switch to region two with a fresh decision value
            xu = 64'(off_x);
            ym1 = 64'(off_y) - 64'd1;
            au = 64'(a_sq);
            bu = 64'(b_sq);
            t = bu * (4 * xu * xu + 4 * xu + 1) + au * (4 * ym1 * ym1) - 4 * au * bu;
            dec = t[47:0];
            ph = PH_R2;
            walk_region_two();
         end
      end else begin
         walk_region_two();
      end
      if (off_y == '0)
         ph = PH_IDLE;
      return mirror_points();
   endfunction

   task automatic report_fault(input string why, input point_group_type exp_g,
                               input point_group_type act_g);
      faults = faults + 1;
      if (faults <= 10) begin
         $display("%0t %s", $time, why);
         $display("   expected act=%0d last=%0d (%0d,%0d) (%0d,%0d) (%0d,%0d) (%0d,%0d)",
                  exp_g.active, exp_g.last_group, $signed(exp_g.p0x), $signed(exp_g.p0y),
                  $signed(exp_g.p1x), $signed(exp_g.p1y), $signed(exp_g.p2x),
                  $signed(exp_g.p2y), $signed(exp_g.p3x), $signed(exp_g.p3y));
         $display("   actual   act=%0d last=%0d (%0d,%0d) (%0d,%0d) (%0d,%0d) (%0d,%0d)",
                  act_g.active, act_g.last_group, $signed(act_g.p0x), $signed(act_g.p0y),
                  $signed(act_g.p1x), $signed(act_g.p1y), $signed(act_g.p2x),
                  $signed(act_g.p2y), $signed(act_g.p3x), $signed(act_g.p3y));
      end
   endtask

   // request acceptance feeds the predictor, response acceptance is checked in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            if (req_kind == KIND_START)
               predicted = start_ellipse(req_corner_ax, req_corner_ay,
                                         req_corner_bx, req_corner_by);
            else
               predicted = advance_ellipse();
            expected_groups.push_back(cur_has_known ? cur_known : predicted);
         end
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_active, rsp_last_group, rsp_pt0_x, rsp_pt0_y, rsp_pt1_x,
                    rsp_pt1_y, rsp_pt2_x, rsp_pt2_y, rsp_pt3_x, rsp_pt3_y};
            if (expected_groups.size() == 0) begin
               report_fault("response with no request outstanding", '0, got);
            end else begin
               want = expected_groups.pop_front();
               if (got !== want)
                  report_fault("point group mismatch", want, got);
            end
         end
      end
   end

   // receiver drops rsp_pop at random in bursts while not quiet
   always @(posedge clock) begin
      if (pop_hold != 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         pop_hold <= $urandom_range(0, 10);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic send_request(input request_type r);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_kind <= r.kind;
      req_corner_ax <= r.ax;
      req_corner_ay <= r.ay;
      req_corner_bx <= r.bx;
      req_corner_by <= r.by;
      cur_has_known <= r.has_known;
      cur_known <= r.known;
      do @(posedge clock); while (req_full);
   endtask

   initial begin
      request_type r;
      int          sent, w, h, x0, y0, nsteps, mode, full;
      directed_rows = '{
         // step with no ellipse after reset
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b1, '0},
         // flat ellipses, two at the corners of the coordinate range
         '{KIND_START, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1,
           '{1'b1, 1'b1, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0}},
         '{KIND_START, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1,
           '{1'b1, 1'b1, 14'd4095, 14'd4095, 14'd4095, 14'd4095,
             14'd4095, 14'd4095, 14'd4095, 14'd4095}},
         '{KIND_STEP,  12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, '0},
         '{KIND_START, 12'd100, 12'd50, 12'd200, 12'd50, 1'b1,
           '{1'b1, 1'b1, 14'd150, 14'd50, 14'd150, 14'd50,
             14'd150, 14'd50, 14'd150, 14'd50}},
         // largest box, then restart mid-ellipse with swapped corners
         '{KIND_START, 12'd0, 12'd0, 12'd4095, 12'd4095, 1'b1,
           '{1'b1, 1'b0, 14'd2047, 14'd4094, 14'd2047, 14'd4094,
             14'd2047, 14'd0, 14'd2047, 14'd0}},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_START, 12'd4095, 12'd4095, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         // zero width walks straight down
         '{KIND_START, 12'd300, 12'd100, 12'd300, 12'd110, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         // small ellipse through both regions and past its end
         '{KIND_START, 12'd0, 12'd0, 12'd6, 12'd4, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0},
         '{KIND_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i]);

      sent = 0;
      while (sent < 700) begin
         if (sent >= 620)
            quiet <= 1'b1;
         mode = $urandom_range(0, 99);
         r = '0;
         r.kind = KIND_START;
         nsteps = 0;
         if (mode < 80) begin
            w = $urandom_range(0, 24);
            h = $urandom_range(0, 24);
            x0 = $urandom_range(0, 4095 - w);
            y0 = $urandom_range(0, 4095 - h);
            if ($urandom_range(0, 1)) begin
               r.ax = CB'(x0); r.bx = CB'(x0 + w);
            end else begin
               r.ax = CB'(x0 + w); r.bx = CB'(x0);
            end
            if ($urandom_range(0, 1)) begin
               r.ay = CB'(y0); r.by = CB'(y0 + h);
            end else begin
               r.ay = CB'(y0 + h); r.by = CB'(y0);
            end
            full = w / 2 + h / 2 + 6;
            nsteps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, full) : full;
         end else begin
            r.ax = CB'($urandom); r.ay = CB'($urandom);
            r.bx = CB'($urandom); r.by = CB'($urandom);
            if (mode < 88)
               nsteps = $urandom_range(0, 8);
            else if ($urandom_range(0, 1))
               r.kind = KIND_STEP;
         end
         send_request(r);
         sent = sent + 1;
         repeat (nsteps) begin
            r.kind = KIND_STEP;
            r.ax = CB'($urandom); r.ay = CB'($urandom);
            r.bx = CB'($urandom); r.by = CB'($urandom);
            send_request(r);
            sent = sent + 1;
         end
      end
      req_push <= 1'b0;

      @(posedge clock);
      while (expected_groups.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (faults == 0)
         $display("midpoint_ellipse_rasterizer regression: pass");
      else
         $display("midpoint_ellipse_rasterizer regression: fail");
      $finish;
   end

   initial begin
      #5ms;
      $display("midpoint_ellipse_rasterizer regression: fail");
      $finish;
   end

endmodule
